// File: rtl/core/dfp_pkg.sv
package dfp_pkg;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_LEN   = 3'd1,
      PH_ID    = 3'd2,
      PH_DATA  = 3'd3,
      PH_FAIL1 = 3'd4,
      PH_FAIL2 = 3'd5,
      PH_FAIL3 = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_MESSAGE = 2'd0,
      KIND_RESTART = 2'd1,
      KIND_FAIL    = 2'd2
   } kind_type;

   localparam logic [7:0] BYTE_HEADER  = 8'h23;  // '#'
   localparam logic [7:0] BYTE_FAIL    = 8'h1A;
   localparam logic [7:0] BYTE_FILL    = 8'hFF;
   localparam logic [7:0] ASCII_ZERO   = 8'h30;  // '0'
   localparam logic [7:0] ID_RESTART   = 8'h40;  // '@'

   // only the first four payload bytes are ever packed into a result
   localparam int PACK_BYTES = 4;
   localparam int PACK_IDX_W = 2;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  id;
      logic [2:0]  len;
      logic [31:0] data;
   } result_type;

endpackage

// File: rtl/core/dfp_parser.sv
module dfp_parser #(
   parameter int PAYLOAD_MAX = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   output logic                 res_valid,
   output dfp_pkg::result_type  res
);

   localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);
   localparam logic [7:0] LEN_LO = 8'(int'(dfp_pkg::ASCII_ZERO) + 2);
   localparam logic [7:0] LEN_HI = 8'(int'(dfp_pkg::ASCII_ZERO) + 1 + PAYLOAD_MAX);

   dfp_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0]   expected_count_ff, expected_count_in;
   logic [CNT_W-1:0]   received_count_ff, received_count_in;
   logic [7:0]         held_id_ff, held_id_in;
   logic [7:0]         store_ff [dfp_pkg::PACK_BYTES];

   logic                          store_we;
   logic [dfp_pkg::PACK_IDX_W-1:0] store_idx;
   logic [CNT_W-1:0]              received_next;
   logic [31:0]                   packed_data;
   logic                          len_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= dfp_pkg::PH_IDLE;
         expected_count_ff <= '0;
         received_count_ff <= '0;
         held_id_ff        <= '0;
      end else if (step) begin
         phase_ff          <= phase_in;
         expected_count_ff <= expected_count_in;
         received_count_ff <= received_count_in;
         held_id_ff        <= held_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && store_we) begin
         store_ff[store_idx] <= rx_byte;
      end
   end

   // the byte that completes a frame is taken straight from the input
   always_comb begin
      packed_data = '0;
      for (int i = 0; i < dfp_pkg::PACK_BYTES; i++) begin
         if (CNT_W'(i) < expected_count_ff) begin
            if (CNT_W'(i) == received_count_ff) begin
               packed_data[8*i +: 8] = rx_byte;
            end else begin
               packed_data[8*i +: 8] = store_ff[i];
            end
         end
      end
   end

   assign received_next = received_count_ff + CNT_W'(1);
   assign store_idx     = received_count_ff[dfp_pkg::PACK_IDX_W-1:0];
   assign len_ok        = (rx_byte >= LEN_LO) && (rx_byte <= LEN_HI);

   always_comb begin
      phase_in          = phase_ff;
      expected_count_in = expected_count_ff;
      received_count_in = received_count_ff;
      held_id_in        = held_id_ff;
      store_we          = 1'b0;
      res_valid         = 1'b0;
      res               = '0;
      unique case (phase_ff)
         dfp_pkg::PH_IDLE: begin
            if (rx_byte == dfp_pkg::BYTE_HEADER) begin
               phase_in = dfp_pkg::PH_LEN;
            end else if (rx_byte == dfp_pkg::BYTE_FAIL) begin
               phase_in = dfp_pkg::PH_FAIL1;
            end
         end
         dfp_pkg::PH_LEN: begin
            if (len_ok) begin
               expected_count_in = CNT_W'(rx_byte - LEN_LO + 8'd1);
               received_count_in = '0;
               phase_in          = dfp_pkg::PH_ID;
            end else begin
               phase_in = dfp_pkg::PH_IDLE;
            end
         end
         dfp_pkg::PH_ID: begin
            held_id_in = rx_byte;
            phase_in   = dfp_pkg::PH_DATA;
         end
         dfp_pkg::PH_DATA: begin
            store_we          = (received_count_ff < CNT_W'(dfp_pkg::PACK_BYTES));
            received_count_in = received_next;
            if (received_next >= expected_count_ff) begin
               phase_in          = dfp_pkg::PH_IDLE;
               received_count_in = '0;
               if (expected_count_ff == CNT_W'(1) || expected_count_ff == CNT_W'(2) ||
                   expected_count_ff == CNT_W'(4)) begin
                  res_valid = 1'b1;
                  res.id    = held_id_ff;
                  res.len   = 3'(expected_count_ff);
                  res.data  = packed_data;
                  if (expected_count_ff == CNT_W'(1) && held_id_ff == dfp_pkg::ID_RESTART) begin
                     res.kind = dfp_pkg::KIND_RESTART;
                  end else begin
                     res.kind = dfp_pkg::KIND_MESSAGE;
                  end
               end
            end
         end
         dfp_pkg::PH_FAIL1: begin
            phase_in = (rx_byte == dfp_pkg::BYTE_FILL) ? dfp_pkg::PH_FAIL2 : dfp_pkg::PH_IDLE;
         end
         dfp_pkg::PH_FAIL2: begin
            phase_in = (rx_byte == dfp_pkg::BYTE_FILL) ? dfp_pkg::PH_FAIL3 : dfp_pkg::PH_IDLE;
         end
         dfp_pkg::PH_FAIL3: begin
            phase_in = dfp_pkg::PH_IDLE;
            if (rx_byte == dfp_pkg::BYTE_FILL) begin
               res_valid = 1'b1;
               res.kind  = dfp_pkg::KIND_FAIL;
            end
         end
         default: begin
            phase_in = dfp_pkg::PH_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/dfp_rsp_reg.sv
module dfp_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  dfp_pkg::result_type  res,
   input  logic                 rsp_stall,
   output logic                 ready,
   output logic                 rsp_valid,
   output dfp_pkg::result_type  rsp_res
);

   logic                valid_ff, valid_in;
   dfp_pkg::result_type res_ff;

   // a held transaction frees the register in the cycle it is taken
   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

// File: rtl/core/display_frame_parser.sv
// display_frame_parser: deframes bytes from a serial display link.
// req channel: one received byte per transaction on req_rx_byte, taken at
//    an edge with req_valid high and req_stall low.
// rsp channel: one result per fail sequence or completed 1-, 2- or 4-byte frame:
//    kind (message, restart request, fail notice), identifier, payload
//    length and up to four payload bytes, first byte in the low bits.
// Frame: '#', length digit, identifier, then length-1 payload bytes.
// Fail notice: 0x1A followed by three 0xFF bytes.
// Path: the byte that completes a result passes the input register, then
//    the result register; rsp_valid rises when the result is loaded there.
// Throughput: one byte per cycle while req_stall is low.
// Stall: bytes that produce no result keep flowing while a result waits;
//    a byte that would produce a result waits in the input register until
//    the result register is free, and req_stall stays high meanwhile.
// Reset: synchronous; returns the parser to idle and empties both
//    registers. No start-up sweep is needed.
module display_frame_parser #(
   parameter int PAYLOAD_MAX = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_result_kind,
   output logic [7:0]   rsp_message_id,
   output logic [2:0]   rsp_payload_length,
   output logic [31:0]  rsp_payload_bytes
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                advance;
   logic                res_valid;
   logic                out_ready;
   dfp_pkg::result_type res;
   dfp_pkg::result_type rsp_res;

   assign advance     = in_valid_ff && (!res_valid || out_ready);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign in_byte_in  = (req_valid && !req_stall) ? req_rx_byte : in_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   dfp_parser #(
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   dfp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res)
   );

   assign rsp_result_kind    = rsp_res.kind;
   assign rsp_message_id     = rsp_res.id;
   assign rsp_payload_length = rsp_res.len;
   assign rsp_payload_bytes  = rsp_res.data;

`ifndef NO_ASSERTIONS
   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == dfp_pkg::KIND_FAIL |->
         rsp_message_id == 8'd0 && rsp_payload_length == 3'd0 && rsp_payload_bytes == 32'd0)
      else $error("fail notice carries nonzero fields");

   a_message_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == dfp_pkg::KIND_MESSAGE |->
         rsp_payload_length == 3'd1 || rsp_payload_length == 3'd2 ||
         rsp_payload_length == 3'd4)
      else $error("message with unsupported payload length");

   a_restart_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == dfp_pkg::KIND_RESTART |->
         rsp_message_id == dfp_pkg::ID_RESTART && rsp_payload_length == 3'd1 &&
         rsp_payload_bytes[31:8] == 24'd0)
      else $error("restart request with wrong fields");

   a_no_load_over_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_bytes))
      else $error("held result overwritten while stalled");
`endif

endmodule
